// ===== rtl/core/wpm_pkg.sv =====
// Package for the wildcard pattern matcher.
// Holds the pattern constants, register addresses and the pattern config type.
// No dependencies.
`default_nettype none

package wpm_pkg;

  // Pattern storage: sixteen bytes in two 64-bit registers
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned LEN_W     = 5;

  // Special pattern bytes
  localparam logic [7:0] WILD_ONE = 8'h3F;  // '?'
  localparam logic [7:0] WILD_RUN = 8'h2A;  // '*'
  localparam logic [7:0] END_BYTE = 8'h00;  // terminator

  // Register index, taken from paddr[4:3]
  localparam logic [1:0] REG_CHARS_LO = 2'd0;
  localparam logic [1:0] REG_CHARS_HI = 2'd1;
  localparam logic [1:0] REG_LENGTH   = 2'd2;

  // Pattern as seen by the matching logic
  typedef struct packed {
    logic [8*PAT_BYTES-1:0] chars;   // byte 0 in bits 7:0
    logic [LEN_W-1:0]       length;
  } wpm_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/wpm_step.sv =====
// One-byte step of the glob position-set automaton.
// Closes '*' positions, advances on the subject byte and evaluates the end.
// Depends on wpm_pkg.
`default_nettype none

module wpm_step #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  wpm_pkg::wpm_cfg_t    cfg,
  input  logic [PATTERN_MAX:0] state,
  input  logic [7:0]           text_byte,
  input  logic                 has_byte,
  input  logic                 end_of_text,
  output logic [PATTERN_MAX:0] state_nxt,
  output logic                 matched_nxt
);
  import wpm_pkg::*;

  localparam int unsigned NW = PATTERN_MAX + 1;
  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

  logic [LEN_W-1:0] len_clamp;
  logic [LW-1:0]    eff_len;
  logic [NW-1:0]    keep;
  logic [NW-2:0]    star;
  logic [NW-2:0]    step;
  logic [NW-1:0]    closed_in;
  logic [NW-1:0]    advanced;
  logic [NW-1:0]    after_byte;
  logic [NW-1:0]    closed_end;

  // Star closure: an active '*' also activates the following position
  function automatic logic [NW-1:0] close_fn(input logic [NW-1:0] set,
                                             input logic [NW-1:0] msk,
                                             input logic [NW-2:0] st);
    logic [NW-1:0] s;
    s = set & msk;
    for (int i = 0; i < NW - 1; i++) begin
      s[i+1] = s[i+1] | (s[i] & st[i]);
    end
    return s;
  endfunction

  // Effective length: clamp, then cut at the first zero byte
  always_comb begin
    if (cfg.length > LEN_W'(PATTERN_MAX)) begin
      len_clamp = LEN_W'(PATTERN_MAX);
    end else begin
      len_clamp = cfg.length;
    end
    eff_len = LW'(len_clamp);
    for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < len_clamp) && (cfg.chars[8*i +: 8] == END_BYTE)) begin
        eff_len = LW'(i);
      end
    end
  end

  // Per-position masks
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      keep[i] = (LW'(i) <= eff_len);
    end
    for (int i = 0; i < NW - 1; i++) begin
      star[i] = (LW'(i) < eff_len) && (cfg.chars[8*i +: 8] == WILD_RUN);
      step[i] = (LW'(i) < eff_len) && !star[i] &&
                ((cfg.chars[8*i +: 8] == WILD_ONE) ||
                 (cfg.chars[8*i +: 8] == text_byte));
    end
  end

  // Advance on the byte, then evaluate the end of the string
  always_comb begin
    closed_in = close_fn(state, keep, star);
    advanced  = '0;
    for (int i = 0; i < NW - 1; i++) begin
      advanced[i]   = advanced[i]   | (closed_in[i] & star[i]);
      advanced[i+1] = advanced[i+1] | (closed_in[i] & step[i]);
    end
    advanced   = advanced & keep;
    after_byte = has_byte ? advanced : state;
    closed_end = close_fn(after_byte, keep, star);
    matched_nxt = closed_end[eff_len];
    if (end_of_text) begin
      state_nxt = NW'(1);
    end else begin
      state_nxt = after_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wildcard_pattern_matcher.sv =====
// Wildcard pattern matcher: '?' and '*' glob over a streamed subject string.
// Stage 1 holds each byte, the result register each verdict; one byte per cycle unless stalled.
// The active-position vector is registered; wpm_step computes each update.
// Reset (rst_n low, synchronous): pattern registers cleared, vector = {0},
// pipeline and result empty.
`default_nettype none

module wildcard_pattern_matcher #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_byte
  input  logic        in_tuser,    // [0] has_byte
  input  logic        in_tlast,    // end_of_text
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] matched, [7:1] zero
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import wpm_pkg::*;

  localparam int unsigned NW = PATTERN_MAX + 1;

  logic [63:0]      chars_lo_r;
  logic [63:0]      chars_hi_r;
  logic [LEN_W-1:0] length_r;
  wpm_cfg_t         cfg;

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_has_r;
  logic             s1_fin_r;
  logic             s1_adv;

  logic [NW-1:0]    state_r;
  logic [NW-1:0]    state_nxt;
  logic             matched_nxt;

  logic             out_valid_r;
  logic             out_matched_r;
  logic             cfg_wr;

  // Register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_lo_r <= '0;
      chars_hi_r <= '0;
      length_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_CHARS_LO: chars_lo_r <= cfg_pwdata;
        REG_CHARS_HI: chars_hi_r <= cfg_pwdata;
        REG_LENGTH:   length_r   <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_paddr[4:3])
      REG_CHARS_LO: cfg_prdata = chars_lo_r;
      REG_CHARS_HI: cfg_prdata = chars_hi_r;
      REG_LENGTH:   cfg_prdata = {{(64-LEN_W){1'b0}}, length_r};
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg.chars  = {chars_hi_r, chars_lo_r};
  assign cfg.length = length_r;

  // Stage 1 moves on unless its end transaction would hit a full result register that is not draining
  assign s1_adv    = s1_valid_r && (!s1_fin_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_has_r  <= in_tuser;
      s1_fin_r  <= in_tlast;
    end
  end

  // Position-set update
  wpm_step #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_step (
    .cfg         (cfg),
    .state       (state_r),
    .text_byte   (s1_byte_r),
    .has_byte    (s1_has_r),
    .end_of_text (s1_fin_r),
    .state_nxt   (state_nxt),
    .matched_nxt (matched_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NW'(1);
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register: a new verdict wins over the drain of the old one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_fin_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_fin_r) begin
      out_matched_r <= matched_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_matched_r};

endmodule

`default_nettype wire
